// ----- design/xmodem_checksum_sender_macros.svh -----
// Assertion macros shared by the XMODEM checksum sender.
`ifndef XMODEM_CHECKSUM_SENDER_MACROS_SVH
`define XMODEM_CHECKSUM_SENDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define XCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define XCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/xcs_pkg.sv -----
// Shared types and constants of the XMODEM checksum sender.
package xcs_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int IDX_W       = $clog2(BLOCK_BYTES);
    localparam int FILL_W      = IDX_W + 1;
    // Frame position: SOH, number, complement, data bytes, checksum.
    localparam int POS_W       = $clog2(BLOCK_BYTES + 4);
    localparam int DATA_FIRST  = 3;
    localparam int SUM_POS     = BLOCK_BYTES + DATA_FIRST;

    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;
    localparam logic [7:0] BYTE_MAX = 8'hFF;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_REPLY = 2'd1;
    localparam logic [1:0] CMD_PULL  = 2'd2;

    localparam logic CFG_NAK_LIMIT = 1'b0;
    localparam logic CFG_PAD_VALUE = 1'b1;

    localparam logic [7:0] NAK_LIMIT_RESET = 8'd10;
    localparam logic [7:0] PAD_VALUE_RESET = 8'd26;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_DATA  = 3'd1,
        PH_SEND  = 3'd2,
        PH_WAIT  = 3'd3,
        PH_DONE  = 3'd4,
        PH_ABORT = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_LOAD  = 3'd1,
        OP_ACK   = 3'd2,
        OP_NAK   = 3'd3,
        OP_OTHER = 3'd4,
        OP_PULL  = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       final_req;
    } t_op;

endpackage

// ----- design/xcs_front.sv -----
// Front end: classifies incoming words and holds them in a two-entry queue.
module xcs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_command,
    input  logic [7:0]    i_value,
    input  logic          i_final_req,
    output logic          o_head_valid,
    output xcs_pkg::t_op  o_head,
    input  logic          i_take
);

    xcs_pkg::t_op r_q [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         w_push;
    xcs_pkg::t_op w_op;

    always_comb begin
        w_op.value     = i_value;
        w_op.final_req = i_final_req;
        case (i_command)
            xcs_pkg::CMD_LOAD:  w_op.kind = xcs_pkg::OP_LOAD;
            xcs_pkg::CMD_REPLY: begin
                if (i_value == xcs_pkg::BYTE_ACK) begin
                    w_op.kind = xcs_pkg::OP_ACK;
                end else if (i_value == xcs_pkg::BYTE_NAK) begin
                    w_op.kind = xcs_pkg::OP_NAK;
                end else begin
                    w_op.kind = xcs_pkg::OP_OTHER;
                end
            end
            xcs_pkg::CMD_PULL:  w_op.kind = xcs_pkg::OP_PULL;
            default:            w_op.kind = xcs_pkg::OP_NOP;
        endcase
    end

    assign o_in_stall   = r_count[1];
    assign w_push       = i_in_valid && !r_count[1];
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_take) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, i_take})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/xcs_back.sv -----
// Back end: protocol engine, block store and result register.
module xcs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_head_valid,
    input  xcs_pkg::t_op  i_head,
    output logic          o_take,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic          o_tx_valid,
    output logic [7:0]    o_tx_byte,
    output logic [2:0]    o_status
);

    localparam int IDX_W  = xcs_pkg::IDX_W;
    localparam int FILL_W = xcs_pkg::FILL_W;
    localparam int POS_W  = xcs_pkg::POS_W;

    logic [7:0] r_mem [xcs_pkg::BLOCK_BYTES];
    logic [7:0] r_rd_data;

    logic [7:0]          r_nak_limit;
    logic [7:0]          r_pad_value;
    xcs_pkg::t_phase     r_phase,   n_phase;
    logic [FILL_W-1:0]   r_fill,    n_fill;
    logic [POS_W-1:0]    r_pos,     n_pos;
    logic [7:0]          r_blk,     n_blk;
    logic [7:0]          r_sum,     n_sum;
    logic [7:0]          r_naks,    n_naks;
    logic                r_started, n_started;
    logic                r_ended,   n_ended;

    logic                r_out_valid;
    logic                r_tx_valid, n_tx_valid;
    logic [7:0]          r_tx_byte,  n_tx_byte;
    logic [2:0]          r_status;

    logic                w_ready;
    logic                w_eot;
    logic                w_we;
    logic [POS_W-1:0]    w_data_idx;
    logic [POS_W-1:0]    w_next_idx;
    logic [7:0]          w_data_byte;

    assign o_take  = i_head_valid && (!r_out_valid || !i_out_stall);
    assign w_ready = (r_fill >= FILL_W'(xcs_pkg::BLOCK_BYTES)) || r_ended;
    assign w_eot   = r_ended && (r_fill == '0);

    assign w_data_idx  = r_pos - POS_W'(xcs_pkg::DATA_FIRST);
    assign w_data_byte = (w_data_idx < POS_W'(r_fill)) ? r_rd_data : r_pad_value;
    // The store is read one step ahead at the next frame position, so the
    // registered data is ready when that position is pulled.
    assign w_next_idx  = n_pos - POS_W'(xcs_pkg::DATA_FIRST);

    always_comb begin
        n_phase    = r_phase;
        n_fill     = r_fill;
        n_pos      = r_pos;
        n_blk      = r_blk;
        n_sum      = r_sum;
        n_naks     = r_naks;
        n_started  = r_started;
        n_ended    = r_ended;
        n_tx_valid = 1'b0;
        n_tx_byte  = 8'd0;
        w_we       = 1'b0;
        if (o_take) begin
            case (i_head.kind)
                xcs_pkg::OP_LOAD: begin
                    if ((r_phase == xcs_pkg::PH_START || r_phase == xcs_pkg::PH_DATA)
                            && !w_ready) begin
                        w_we    = 1'b1;
                        n_fill  = r_fill + FILL_W'(1);
                        n_ended = r_ended || i_head.final_req;
                        if (((n_fill >= FILL_W'(xcs_pkg::BLOCK_BYTES)) || n_ended)
                                && r_started) begin
                            n_phase = xcs_pkg::PH_SEND;
                            n_pos   = '0;
                        end
                    end
                end
                xcs_pkg::OP_ACK: begin
                    if (r_phase == xcs_pkg::PH_WAIT) begin
                        if (w_eot) begin
                            n_phase = xcs_pkg::PH_DONE;
                        end else begin
                            n_blk   = r_blk + 8'd1;
                            n_fill  = '0;
                            n_pos   = '0;
                            n_phase = r_ended ? xcs_pkg::PH_SEND : xcs_pkg::PH_DATA;
                        end
                    end
                end
                xcs_pkg::OP_NAK: begin
                    if (r_phase == xcs_pkg::PH_START) begin
                        // The opening NAK starts the transfer and is not counted.
                        n_started = 1'b1;
                        n_phase   = w_ready ? xcs_pkg::PH_SEND : xcs_pkg::PH_DATA;
                        n_pos     = '0;
                    end else if (r_phase == xcs_pkg::PH_WAIT) begin
                        if (r_naks != xcs_pkg::BYTE_MAX) begin
                            n_naks = r_naks + 8'd1;
                        end
                        if (n_naks > r_nak_limit) begin
                            n_phase = xcs_pkg::PH_ABORT;
                        end else begin
                            n_phase = xcs_pkg::PH_SEND;
                            n_pos   = '0;
                        end
                    end
                end
                xcs_pkg::OP_PULL: begin
                    if (r_phase == xcs_pkg::PH_SEND) begin
                        n_tx_valid = 1'b1;
                        if (w_eot) begin
                            n_tx_byte = xcs_pkg::BYTE_EOT;
                            n_phase   = xcs_pkg::PH_WAIT;
                        end else if (r_pos == POS_W'(0)) begin
                            n_tx_byte = xcs_pkg::BYTE_SOH;
                            n_sum     = 8'd0;
                            n_pos     = r_pos + POS_W'(1);
                        end else if (r_pos == POS_W'(1)) begin
                            n_tx_byte = r_blk;
                            n_pos     = r_pos + POS_W'(1);
                        end else if (r_pos == POS_W'(2)) begin
                            n_tx_byte = ~r_blk;
                            n_pos     = r_pos + POS_W'(1);
                        end else if (r_pos < POS_W'(xcs_pkg::SUM_POS)) begin
                            n_tx_byte = w_data_byte;
                            n_sum     = r_sum + w_data_byte;
                            n_pos     = r_pos + POS_W'(1);
                        end else begin
                            n_tx_byte = r_sum;
                            n_phase   = xcs_pkg::PH_WAIT;
                            n_pos     = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_fill[IDX_W-1:0]] <= i_head.value;
        end
        r_rd_data <= r_mem[w_next_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nak_limit <= xcs_pkg::NAK_LIMIT_RESET;
            r_pad_value <= xcs_pkg::PAD_VALUE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == xcs_pkg::CFG_NAK_LIMIT) begin
                r_nak_limit <= i_cfg_data;
            end else begin
                r_pad_value <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= xcs_pkg::PH_START;
            r_fill      <= '0;
            r_pos       <= '0;
            r_blk       <= 8'd1;
            r_sum       <= 8'd0;
            r_naks      <= 8'd0;
            r_started   <= 1'b0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_fill    <= n_fill;
            r_pos     <= n_pos;
            r_blk     <= n_blk;
            r_sum     <= n_sum;
            r_naks    <= n_naks;
            r_started <= n_started;
            r_ended   <= n_ended;
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_tx_valid <= n_tx_valid;
            r_tx_byte  <= n_tx_byte;
            r_status   <= n_phase;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_valid  = r_tx_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_status    = r_status;

endmodule

// ----- design/xmodem_checksum_sender.sv -----
// Top level of the XMODEM checksum sender: front queue and protocol engine.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------
//   input    | i_in_valid / o_in_stall    | i_command, i_value, i_final_req
//   output   | o_out_valid / i_out_stall  | o_tx_valid, o_tx_byte, o_status
//   config   | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One word is accepted per cycle while o_in_stall is low and one result word leaves
// per cycle while i_out_stall is low. The engine takes one queued word per cycle
// unless the result register is held by output stall; the block store has a single
// write port and its read is registered one frame position ahead.
// Reset is synchronous; the block store is not cleared.
// The two-word queue takes one more input word while the output stalls.
module xmodem_checksum_sender (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_value,
    input  logic       i_final_req,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic [2:0] o_status
);

    `include "xmodem_checksum_sender_macros.svh"

    logic         w_head_valid;
    xcs_pkg::t_op w_head;
    logic         w_take;

    xcs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_value      (i_value),
        .i_final_req  (i_final_req),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_take       (w_take)
    );

    xcs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_take       (w_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_tx_valid   (o_tx_valid),
        .o_tx_byte    (o_tx_byte),
        .o_status     (o_status)
    );

    `XCS_ASSERT_NOW(a_take_needs_word, i_clk, i_rst_n, w_take, w_head_valid, "engine took from an empty queue")
    `XCS_ASSERT_NOW(a_tx_in_send_phase, i_clk, i_rst_n, o_out_valid && o_tx_valid, (o_status == xcs_pkg::PH_SEND) || (o_status == xcs_pkg::PH_WAIT), "line byte sent outside a frame")
    `XCS_ASSERT_NOW(a_idle_pull_zero, i_clk, i_rst_n, o_out_valid && !o_tx_valid, o_tx_byte == 8'd0, "idle result carries a nonzero byte")
    `XCS_ASSERT_NEXT(a_stall_when_full, i_clk, i_rst_n, o_in_stall && !w_take, o_in_stall, "queue full flag dropped without a pop")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the XMODEM checksum sender: random words in, predicted line bytes out.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import xcs_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 500;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] status;
    } t_line_word;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_index = 1'b0;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_command   = CMD_LOAD;
    logic [7:0] i_value     = 8'h00;
    logic       i_final_req = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic [2:0] o_status;

    // Mirror of the sender's state and registers.
    t_phase     sender_phase   = PH_START;
    logic [7:0] blk_data[BLOCK_BYTES];
    int         blk_fill       = 0;
    int         frame_pos      = 0;
    logic [7:0] blk_num        = 8'd1;
    logic [7:0] frame_sum      = 8'h00;
    logic [7:0] nak_total      = 8'h00;
    logic       start_nak_seen = 1'b0;
    logic       file_done      = 1'b0;
    logic [7:0] nak_limit_reg  = NAK_LIMIT_RESET;
    logic [7:0] pad_byte_reg   = PAD_VALUE_RESET;

    t_line_word tx_due[$];
    int         mismatches    = 0;
    int         in_idle_pct   = 25;
    int         out_stall_pct = 25;
    int         hold_left     = 0;

    xmodem_checksum_sender dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_value     (i_value),
        .i_final_req (i_final_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_tx_valid  (o_tx_valid),
        .o_tx_byte   (o_tx_byte),
        .o_status    (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic store_ready();
        return blk_fill >= BLOCK_BYTES || file_done;
    endfunction

    function automatic logic [7:0] frame_byte();
        logic [7:0] b;
        int         idx;
        // An ended file with an empty store means the lone EOT is due.
        if (file_done && blk_fill == 0) begin
            sender_phase = PH_WAIT;
            return BYTE_EOT;
        end
        if (frame_pos == 0) begin
            b = BYTE_SOH;
            frame_sum = 8'h00;
        end else if (frame_pos == 1) begin
            b = blk_num;
        end else if (frame_pos == 2) begin
            b = blk_num ^ BYTE_MAX;
        end else if (frame_pos < SUM_POS) begin
            idx = frame_pos - DATA_FIRST;
            b = (idx < blk_fill) ? blk_data[idx] : pad_byte_reg;
            frame_sum = frame_sum + b;
        end else begin
            sender_phase = PH_WAIT;
            frame_pos = 0;
            return frame_sum;
        end
        frame_pos++;
        return b;
    endfunction

    function automatic t_line_word step_sender(logic [1:0] cmd, logic [7:0] val, logic last);
        t_line_word w;
        w = '0;
        case (cmd)
            CMD_LOAD: begin
                if ((sender_phase == PH_START || sender_phase == PH_DATA) && !store_ready()) begin
                    blk_data[blk_fill] = val;
                    blk_fill++;
                    if (last)
                        file_done = 1'b1;
                    if (store_ready() && start_nak_seen) begin
                        sender_phase = PH_SEND;
                        frame_pos = 0;
                    end
                end
            end
            CMD_REPLY: begin
                if (sender_phase == PH_START) begin
                    if (val == BYTE_NAK) begin
                        start_nak_seen = 1'b1;
                        sender_phase = store_ready() ? PH_SEND : PH_DATA;
                        frame_pos = 0;
                    end
                end else if (sender_phase == PH_WAIT) begin
                    if (val == BYTE_ACK) begin
                        if (file_done && blk_fill == 0) begin
                            sender_phase = PH_DONE;
                        end else begin
                            blk_num = blk_num + 8'd1;
                            blk_fill = 0;
                            frame_pos = 0;
                            sender_phase = file_done ? PH_SEND : PH_DATA;
                        end
                    end else if (val == BYTE_NAK) begin
                        if (nak_total != BYTE_MAX)
                            nak_total++;
                        if (nak_total > nak_limit_reg) begin
                            sender_phase = PH_ABORT;
                        end else begin
                            sender_phase = PH_SEND;
                            frame_pos = 0;
                        end
                    end
                end
            end
            CMD_PULL: begin
                if (sender_phase == PH_SEND) begin
                    w.tx_byte = frame_byte();
                    w.tx_valid = 1'b1;
                end
            end
            default: ;
        endcase
        w.status = sender_phase;
        return w;
    endfunction

    task automatic offer_word(logic [1:0] cmd, logic [7:0] val, logic last);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_value     <= val;
        i_final_req <= last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        tx_due.push_back(step_sender(cmd, val, last));
    endtask

    // Registers change only once every result is out and the engine has settled.
    task automatic write_reg(logic idx, logic [7:0] data);
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (tx_due.size() != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_NAK_LIMIT)
            nak_limit_reg = data;
        else
            pad_byte_reg = data;
    endtask

    task automatic send_frame();
        while (sender_phase == PH_START || sender_phase == PH_SEND) begin
            if (sender_phase == PH_START)
                offer_word(CMD_REPLY, BYTE_NAK, 1'b0);
            else
                offer_word(CMD_PULL, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_start_phase();
        offer_word(CMD_PULL, 8'hFF, 1'b1);
        offer_word(CMD_UNUSED, 8'hFF, 1'b1);
        offer_word(CMD_REPLY, BYTE_ACK, 1'b0);
        offer_word(CMD_REPLY, 8'h00, 1'b0);
        offer_word(CMD_REPLY, 8'hFF, 1'b1);
        offer_word(CMD_UNUSED, 8'h00, 1'b0);
        offer_word(CMD_LOAD, 8'h00, 1'b0);
        offer_word(CMD_LOAD, 8'hFF, 1'b0);
        offer_word(CMD_PULL, 8'h00, 1'b0);
    endtask

    task automatic test_backpressure();
        in_idle_pct = 0;
        hold_left = 100;
        repeat (24)
            offer_word(CMD_LOAD, 8'($urandom_range(255)), 1'b0);
        in_idle_pct = 25;
    endtask

    task automatic test_random_transfer();
        int         moved;
        int         tail_len;
        int         lim_lo;
        int         pick;
        logic [7:0] cfg_blk;
        logic [7:0] v;
        logic       last;
        moved = 0;
        pick = $urandom_range(3);
        tail_len = (pick == 0) ? 1 : (pick == 1) ? BLOCK_BYTES : $urandom_range(BLOCK_BYTES, 1);
        cfg_blk = blk_num;
        write_reg(CFG_NAK_LIMIT, 8'hFF);
        while (!file_done && sender_phase != PH_ABORT) begin
            in_idle_pct = (moved >= 300 && moved < 500) ? 0 : 25;
            out_stall_pct = in_idle_pct;
            if (sender_phase == PH_DATA && blk_fill == 0 && blk_num != cfg_blk) begin
                cfg_blk = blk_num;
                lim_lo = (nak_total > 235) ? 255 : nak_total + 20;
                write_reg(CFG_PAD_VALUE, 8'($urandom_range(255)));
                write_reg(CFG_NAK_LIMIT, 8'($urandom_range(255, lim_lo)));
            end
            v = 8'($urandom_range(255));
            last = (moved >= RANDOM_ITEMS) && (blk_fill + 1 >= tail_len);
            if ($urandom_range(99) < 10) begin
                // Stray words; a stray last-byte flag would cut the file short while loading.
                if (sender_phase == PH_START || sender_phase == PH_DATA)
                    offer_word(2'($urandom_range(3)), v, 1'b0);
                else
                    offer_word(2'($urandom_range(3)), v, 1'($urandom_range(1)));
            end else begin
                moved++;
                case (sender_phase)
                    PH_START: begin
                        // The start NAK is rare, so the store often fills up first.
                        if ($urandom_range(99) == 0 || (store_ready() && $urandom_range(1)))
                            offer_word(CMD_REPLY, BYTE_NAK, 1'b0);
                        else
                            offer_word(CMD_LOAD, v, last);
                    end
                    PH_DATA:  offer_word(CMD_LOAD, v, last);
                    PH_SEND:  offer_word(CMD_PULL, v, 1'b0);
                    PH_WAIT: begin
                        pick = $urandom_range(99);
                        if (pick < 70)
                            offer_word(CMD_REPLY, BYTE_ACK, 1'b0);
                        else if (pick < 90)
                            offer_word(CMD_REPLY, BYTE_NAK, 1'b0);
                        else
                            offer_word(CMD_REPLY, v, 1'b0);
                    end
                    default: ;
                endcase
            end
        end
        in_idle_pct = 25;
        out_stall_pct = 25;
    endtask

    task automatic test_final_block();
        logic abort_path;
        abort_path = 1'($urandom_range(1));
        if (sender_phase != PH_ABORT) begin
            // The final block is resent under different fill bytes.
            write_reg(CFG_NAK_LIMIT, 8'hFF);
            write_reg(CFG_PAD_VALUE, 8'h00);
            send_frame();
            offer_word(CMD_REPLY, BYTE_NAK, 1'b0);
            write_reg(CFG_PAD_VALUE, 8'hFF);
            send_frame();
            offer_word(CMD_REPLY, BYTE_NAK, 1'b0);
            write_reg(CFG_PAD_VALUE, 8'($urandom_range(255)));
            send_frame();
            if (abort_path) begin
                // A NAK total equal to the limit still resends; one above aborts.
                write_reg(CFG_NAK_LIMIT, nak_total + 8'd1);
                offer_word(CMD_REPLY, BYTE_NAK, 1'b0);
                send_frame();
                write_reg(CFG_NAK_LIMIT, 8'h00);
                offer_word(CMD_REPLY, BYTE_NAK, 1'b0);
            end else begin
                offer_word(CMD_REPLY, BYTE_ACK, 1'b0);
                send_frame();
                offer_word(CMD_REPLY, BYTE_NAK, 1'b0);
                send_frame();
                offer_word(CMD_REPLY, BYTE_ACK, 1'b0);
            end
        end
    endtask

    task automatic test_terminal_hold();
        offer_word(CMD_PULL, 8'h00, 1'b0);
        offer_word(CMD_LOAD, 8'hA5, 1'b1);
        offer_word(CMD_REPLY, BYTE_NAK, 1'b0);
        offer_word(CMD_REPLY, BYTE_ACK, 1'b0);
        offer_word(CMD_UNUSED, 8'hFF, 1'b1);
        offer_word(CMD_PULL, 8'hFF, 1'b1);
    endtask

    // Receiver: random stall, or a long hold-off while a count runs down.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_line_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tx_due.size() == 0) begin
                $error("result word with no word outstanding");
                mismatches++;
            end else begin
                want = tx_due.pop_front();
                if (o_tx_valid !== want.tx_valid) begin
                    $error("tx_valid: expected %0d, got %0d", want.tx_valid, o_tx_valid);
                    mismatches++;
                end
                if (o_tx_byte !== want.tx_byte) begin
                    $error("tx_byte: expected %02h, got %02h", want.tx_byte, o_tx_byte);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("xmodem_checksum_sender verification failed");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_start_phase();
        test_backpressure();
        test_random_transfer();
        test_final_block();
        test_terminal_hold();
        i_in_valid <= 1'b0;
        for (int k = 0; k < 2000 && tx_due.size() != 0; k++)
            @(posedge i_clk);
        if (tx_due.size() != 0) begin
            $error("%0d result words never arrived", tx_due.size());
            mismatches++;
        end
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("xmodem_checksum_sender verification clean");
        else
            $display("xmodem_checksum_sender verification failed");
        $finish;
    end

endmodule
